// File: design/tcw_pkg.sv
// Package for the text console character writer.
// Holds screen geometry, field widths, operation, register and character codes,
// reset values and sweep bounds. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths
  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int TAB_W     = 4;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_STEP  = 2'd1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Reset values
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [TAB_W-1:0]  RESET_TAB  = 4'd4;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Sweep bounds
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(COLUMNS * (ROWS - 1));
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

endpackage

// File: design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/text_console_char_writer.sv
// Text console character writer: cursor sequencer over a screen RAM.
// Depends on tcw_pkg and tcw_ram.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+--------------------------------------------
//   command   | start / busy            | op, char_code, read_col, read_row
//   result    | done (one-cycle strobe) | cell_char, cell_attr, cursor_col, cursor_row
//   config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A command is taken when start is high and busy is low; the result strobes
// done for one cycle. A put that scrolls adds a row copy (one RAM read then
// one write per cell) and then blanks the bottom row; a clear writes each
// cell in turn and then gives the result. After reset the screen RAM is
// swept to blanks with busy high; configuration writes are taken throughout.
// The receiver cannot stall results.
`timescale 1ns / 1ps

module text_console_char_writer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [tcw_pkg::OP_W-1:0]        op,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::COL_W-1:0]       read_col,
  input  logic [tcw_pkg::ROW_W-1:0]       read_row,
  output logic                            done,
  output logic [tcw_pkg::CHAR_W-1:0]      cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]      cell_attr,
  output logic [tcw_pkg::COL_W-1:0]       cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]       cursor_row,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INIT      = 4'd1;
  localparam logic [3:0] S_PUT       = 4'd2;
  localparam logic [3:0] S_SCROLL_RD = 4'd3;
  localparam logic [3:0] S_SCROLL_WR = 4'd4;
  localparam logic [3:0] S_BLANK     = 4'd5;
  localparam logic [3:0] S_CLEAR     = 4'd6;
  localparam logic [3:0] S_READ      = 4'd7;
  localparam logic [3:0] S_RD_WAIT   = 4'd8;

  logic [3:0]                   state;
  logic [tcw_pkg::ADDR_W-1:0]   ptr;
  logic [tcw_pkg::ATTR_W-1:0]   attribute;
  logic [tcw_pkg::TAB_W-1:0]    tab_step;
  logic [tcw_pkg::COL_W-1:0]    cur_col;
  logic [tcw_pkg::ROW_W-1:0]    cur_row;
  logic [tcw_pkg::CHAR_W-1:0]   char_q;
  logic [tcw_pkg::COL_W-1:0]    rd_col_q;
  logic [tcw_pkg::ROW_W-1:0]    rd_row_q;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char_q;
  logic [tcw_pkg::ATTR_W-1:0]   cell_attr_q;
  logic                         done_q;

  // RAM ports
  logic                         ram_we;
  logic [tcw_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
  logic [tcw_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

  // Shared address unit
  logic [tcw_pkg::ROW_W-1:0]    addr_row;
  logic [tcw_pkg::COL_W-1:0]    addr_col;
  logic [tcw_pkg::ADDR_W-1:0]   lin_addr;

  // Cursor update
  logic [tcw_pkg::COL_W:0]      col_t;
  logic [tcw_pkg::ROW_W:0]      row_t;
  logic                         wr_char;
  logic                         need_scroll;
  logic                         rd_in_range;
  logic [tcw_pkg::CELL_W-1:0]   blank_cell;

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign done       = done_q;
  assign cell_char  = cell_char_q;
  assign cell_attr  = cell_attr_q;
  assign cursor_col = cur_col;
  assign cursor_row = cur_row;
  assign blank_cell = {attribute, tcw_pkg::CH_SPACE};

  // Row-major address of either the cursor or the read cell
  assign addr_row = (state == S_READ) ? rd_row_q : cur_row;
  assign addr_col = (state == S_READ) ? rd_col_q : cur_col;
  assign lin_addr = tcw_pkg::ADDR_W'(addr_row) * tcw_pkg::ROW_STRIDE
                  + tcw_pkg::ADDR_W'(addr_col);

  assign rd_in_range = (rd_col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
                    && (rd_row_q < tcw_pkg::ROW_W'(tcw_pkg::ROWS));

  // Work out the cursor after a put, with wrap and scroll
  always_comb begin
    col_t   = {1'b0, cur_col};
    row_t   = {1'b0, cur_row};
    wr_char = 1'b0;
    case (char_q)
      tcw_pkg::CH_NEWLINE: begin
        col_t = '0;
        row_t = row_t + 1'b1;
      end
      tcw_pkg::CH_RETURN: begin
        col_t = '0;
      end
      tcw_pkg::CH_BACKSPACE: begin
        if (cur_col != '0) begin
          col_t = col_t - 1'b1;
        end
      end
      tcw_pkg::CH_TAB: begin
        col_t = col_t + (tcw_pkg::COL_W + 1)'(tab_step);
      end
      default: begin
        wr_char = 1'b1;
        col_t   = col_t + 1'b1;
      end
    endcase
    if (col_t > (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS - 1)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    need_scroll = (row_t > (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS - 1));
  end

  // Drive the RAM from the sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = blank_cell;
    ram_raddr = ptr + tcw_pkg::ROW_STRIDE;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_CELL;
      end
      S_PUT: begin
        ram_we    = wr_char;
        ram_waddr = lin_addr;
        ram_wdata = {attribute, char_q};
      end
      S_SCROLL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_BLANK, S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_READ: begin
        ram_raddr = lin_addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::RESET_ATTR;
      tab_step  <= tcw_pkg::RESET_TAB;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcw_pkg::CFG_ATTRIBUTE: attribute <= cfg_data;
        tcw_pkg::CFG_TAB_STEP:  tab_step  <= cfg_data[tcw_pkg::TAB_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the command payload on acceptance
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      char_q   <= char_code;
      rd_col_q <= read_col;
      rd_row_q <= read_row;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      ptr         <= '0;
      cur_col     <= '0;
      cur_row     <= '0;
      done_q      <= 1'b0;
      cell_char_q <= '0;
      cell_attr_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cell_char_q <= '0;
            cell_attr_q <= '0;
            ptr         <= '0;
            unique case (op)
              tcw_pkg::OP_PUT:   state <= S_PUT;
              tcw_pkg::OP_READ:  state <= S_READ;
              tcw_pkg::OP_CLEAR: state <= S_CLEAR;
              default:           done_q <= 1'b1;
            endcase
          end
        end
        S_INIT: begin
          ptr <= ptr + 1'b1;
          if (ptr == tcw_pkg::LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_PUT: begin
          if (need_scroll) begin
            cur_col <= '0;
            cur_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
            ptr     <= '0;
            state   <= S_SCROLL_RD;
          end else begin
            cur_col <= col_t[tcw_pkg::COL_W-1:0];
            cur_row <= row_t[tcw_pkg::ROW_W-1:0];
            done_q  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_SCROLL_RD: begin
          state <= S_SCROLL_WR;
        end
        S_SCROLL_WR: begin
          if (ptr == tcw_pkg::SCROLL_LAST) begin
            ptr   <= tcw_pkg::BOTTOM_ROW;
            state <= S_BLANK;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_SCROLL_RD;
          end
        end
        S_BLANK, S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == tcw_pkg::LAST_CELL) begin
            done_q <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (rd_in_range) begin
            cell_char_q <= ram_rdata[tcw_pkg::CHAR_W-1:0];
            cell_attr_q <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          end
          done_q <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/tcw_checker.sv
// Port-level checker for the text console character writer, with its bind.
// Depends on tcw_pkg; attaches to text_console_char_writer.
`timescale 1ns / 1ps

module tcw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [tcw_pkg::COL_W-1:0]     cursor_col,
  input logic [tcw_pkg::ROW_W-1:0]     cursor_row
);

  // Reset starts the clearing sweep and drops any pending result
  a_reset_sweep: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("reset did not start the screen sweep");

  // A result only appears once the sequencer has returned to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted command either starts work or finishes at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command was dropped");

  // The cursor only moves while a command is in progress
  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !busy |=> ($stable(cursor_col) && $stable(cursor_row)))
    else $error("cursor moved while idle");

  // The cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
    && (cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
    else $error("cursor off screen");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row)
);
